FILE: design/square_bounding_box_of_lit_pixels_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the square bounding box unit
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SQUARE_BOUNDING_BOX_OF_LIT_PIXELS_UNIT_DEFINES_SVH
`define SQUARE_BOUNDING_BOX_OF_LIT_PIXELS_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define SBBL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbbl same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted.
`define SBBL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbbl next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SBBL_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sbbl reset check failed");

`endif

FILE: design/sbbl_pkg.sv
// ----------------------------------------------------------------------------
// sbbl_pkg
// Types, constants and helpers shared by the square bounding box unit.
// ----------------------------------------------------------------------------
package sbbl_pkg;

    // Largest frame dimension; positions are counted below it.
    localparam int MAX_DIM = 4096;
    localparam int POS_W   = $clog2(MAX_DIM);

    // Fixed field widths.
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 8;
    localparam int SIDE_W  = 13;
    localparam int OUT_POS_W = 12;

    // Reset frame size.
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // side = (span * 23 + 19) / 20, done as ((n >> 2) * RECIP5) >> RECIP5_SH.
    localparam int SCALE_MUL = 23;
    localparam int SCALE_ADD = 19;
    localparam int NUM_W     = POS_W + 5;
    localparam int QUART_W   = NUM_W - 2;
    localparam int RECIP5    = 52429;
    localparam int RECIP5_SH = 18;
    localparam int PROD_W    = QUART_W + 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 8'd0,
        REG_FRAME_HEIGHT = 8'd1
    } t_cfg_reg;

    // Extremes of one finished frame.
    typedef struct packed {
        logic [POS_W-1:0] min_col;
        logic [POS_W-1:0] max_col;
        logic [POS_W-1:0] min_row;
        logic [POS_W-1:0] max_row;
        logic             seen;
    } t_frame_ext;

    // One box result.
    typedef struct packed {
        logic [OUT_POS_W-1:0] left;
        logic [OUT_POS_W-1:0] top;
        logic [SIDE_W-1:0]    side;
        logic                 empty;
    } t_box;

    // Index of the last column or row for a programmed size. Zero counts as
    // one and anything above the maximum saturates at it.
    function automatic logic [POS_W-1:0] size_to_last(input logic [CFG_W-1:0] size);
        logic [POS_W-1:0] last;
        if (size == '0) begin
            last = '0;
        end else if (32'(size) > MAX_DIM) begin
            last = POS_W'(MAX_DIM - 1);
        end else begin
            last = POS_W'(size - 1'b1);
        end
        return last;
    endfunction

endpackage

FILE: design/square_bounding_box_of_lit_pixels_unit.sv
// ----------------------------------------------------------------------------
// square_bounding_box_of_lit_pixels_unit
// Square box around the lit pixels of a raster frame, one box per frame.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Word
//  --------  ---------  ------------------------  -------------------------------
//  pixel     in         i_valid / o_stall         i_blue, i_green, i_red
//  box       out        o_valid / i_stall         o_box_left/top/side/empty
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A pixel word can be taken in every clock. The edge that takes a frame's
// last pixel loads its extremes register; the box then passes through the
// three box pipeline stages ahead of the output register. The pixel input
// stalls only while a finished frame's extremes wait for a full, stalled box
// pipeline. Reset is synchronous and active low; it restores a 640 by 480
// frame and clears the counters. Config is always ready.
//
module square_bounding_box_of_lit_pixels_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Pixel input.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [7:0]                     i_blue,
    input  logic [7:0]                     i_green,
    input  logic [7:0]                     i_red,
    // Box output.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [11:0]                    o_box_left,
    output logic [11:0]                    o_box_top,
    output logic [12:0]                    o_box_side,
    output logic                           o_box_empty,
    // Register writes.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sbbl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbbl_pkg::CFG_W-1:0]     i_cfg_data
);

    // The frame size is kept as the index of the last column and row, already
    // clamped, so the counters compare against it directly.
    logic [sbbl_pkg::POS_W-1:0] r_last_col, r_last_row;

    sbbl_pkg::t_frame_ext ext;
    logic                 ext_valid, ext_ready, lit;
    sbbl_pkg::t_box       box;

    assign o_cfg_ready = 1'b1;

    // Writes to an index beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= sbbl_pkg::size_to_last(
                sbbl_pkg::CFG_W'(sbbl_pkg::FRAME_WIDTH_RST));
            r_last_row <= sbbl_pkg::size_to_last(
                sbbl_pkg::CFG_W'(sbbl_pkg::FRAME_HEIGHT_RST));
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sbbl_pkg::REG_FRAME_WIDTH: begin
                    r_last_col <= sbbl_pkg::size_to_last(i_cfg_data);
                end
                sbbl_pkg::REG_FRAME_HEIGHT: begin
                    r_last_row <= sbbl_pkg::size_to_last(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    // A pixel counts as lit when any colour byte is nonzero.
    assign lit = |{i_blue, i_green, i_red};

    sbbl_frame_acc u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_lit       (lit),
        .i_last_col  (r_last_col),
        .i_last_row  (r_last_row),
        .o_ext       (ext),
        .o_ext_valid (ext_valid),
        .i_ext_ready (ext_ready)
    );

    sbbl_box_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ext       (ext),
        .i_ext_valid (ext_valid),
        .o_ext_ready (ext_ready),
        .o_box       (box),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

    assign o_box_left  = box.left;
    assign o_box_top   = box.top;
    assign o_box_side  = box.side;
    assign o_box_empty = box.empty;

endmodule

FILE: design/sbbl_frame_acc.sv
// ----------------------------------------------------------------------------
// sbbl_frame_acc
// Raster position counters and running extremes of the lit pixels.
// ----------------------------------------------------------------------------
module sbbl_frame_acc (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_lit,
    input  logic [sbbl_pkg::POS_W-1:0] i_last_col,
    input  logic [sbbl_pkg::POS_W-1:0] i_last_row,
    output sbbl_pkg::t_frame_ext       o_ext,
    output logic                       o_ext_valid,
    input  logic                       i_ext_ready
);

    logic [sbbl_pkg::POS_W-1:0] r_col, r_row;
    logic [sbbl_pkg::POS_W-1:0] r_min_col, r_max_col, r_min_row, r_max_row;
    logic                       r_seen;
    sbbl_pkg::t_frame_ext       r_ext;
    logic                       r_ext_valid;

    logic [sbbl_pkg::POS_W-1:0] n_min_col, n_max_col, n_min_row, n_max_row;
    logic                       n_seen;
    logic                       last_col, last_row, accept, ready;

    always_comb begin
        n_min_col = (i_lit && (r_col < r_min_col)) ? r_col : r_min_col;
        n_max_col = (i_lit && (r_col > r_max_col)) ? r_col : r_max_col;
        n_min_row = (i_lit && (r_row < r_min_row)) ? r_row : r_min_row;
        n_max_row = (i_lit && (r_row > r_max_row)) ? r_row : r_max_row;
        n_seen    = r_seen | i_lit;
        // A size shrunk mid frame wraps or ends at once.
        last_col  = (r_col >= i_last_col);
        last_row  = (r_row >= i_last_row);
        ready     = !r_ext_valid || i_ext_ready;
        accept    = i_valid && ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_min_col   <= '1;
            r_max_col   <= '0;
            r_min_row   <= '1;
            r_max_row   <= '0;
            r_seen      <= 1'b0;
            r_ext_valid <= 1'b0;
        end else begin
            if (i_ext_ready) begin
                r_ext_valid <= 1'b0;
            end
            if (accept) begin
                if (last_col && last_row) begin
                    r_ext_valid   <= 1'b1;
                    r_ext.min_col <= n_min_col;
                    r_ext.max_col <= n_max_col;
                    r_ext.min_row <= n_min_row;
                    r_ext.max_row <= n_max_row;
                    r_ext.seen    <= n_seen;
                    r_col         <= '0;
                    r_row         <= '0;
                    r_min_col     <= '1;
                    r_max_col     <= '0;
                    r_min_row     <= '1;
                    r_max_row     <= '0;
                    r_seen        <= 1'b0;
                end else begin
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    r_min_col <= n_min_col;
                    r_max_col <= n_max_col;
                    r_min_row <= n_min_row;
                    r_max_row <= n_max_row;
                    r_seen    <= n_seen;
                end
            end
        end
    end

    assign o_stall     = !ready;
    assign o_ext       = r_ext;
    assign o_ext_valid = r_ext_valid;

endmodule

FILE: design/sbbl_box_calc.sv
// ----------------------------------------------------------------------------
// sbbl_box_calc
// Four-stage pipeline from frame extremes to the square box.
// ----------------------------------------------------------------------------
module sbbl_box_calc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sbbl_pkg::t_frame_ext i_ext,
    input  logic                 i_ext_valid,
    output logic                 o_ext_ready,
    output sbbl_pkg::t_box       o_box,
    output logic                 o_valid,
    input  logic                 i_stall
);

    // Stage 1: centres and larger span.
    logic                         r_v1, r_e1;
    logic [sbbl_pkg::POS_W-1:0]   r_span1, r_cx1, r_cy1;
    // Stage 2: scaled numerator.
    logic                         r_v2, r_e2;
    logic [sbbl_pkg::NUM_W-1:0]   r_num2;
    logic [sbbl_pkg::POS_W-1:0]   r_cx2, r_cy2;
    // Stage 3: reciprocal product.
    logic                         r_v3, r_e3;
    logic [sbbl_pkg::PROD_W-1:0]  r_prod3;
    logic [sbbl_pkg::POS_W-1:0]   r_cx3, r_cy3;
    // Stage 4: output register.
    logic                         r_v4;
    sbbl_pkg::t_box               r_box;

    logic                         rdy1, rdy2, rdy3, rdy4;
    logic [sbbl_pkg::POS_W-1:0]   sw, sh, n_cx, n_cy, n_span;
    logic [sbbl_pkg::NUM_W-1:0]   n_num;
    logic [sbbl_pkg::QUART_W-1:0] quart;
    logic [sbbl_pkg::PROD_W-1:0]  n_prod;
    logic [sbbl_pkg::SIDE_W-1:0]  side;
    logic [sbbl_pkg::POS_W-1:0]   half, left, top;

    always_comb begin
        rdy4 = !r_v4 || !i_stall;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;

        sw     = i_ext.max_col - i_ext.min_col;
        sh     = i_ext.max_row - i_ext.min_row;
        n_cx   = i_ext.min_col + (sw >> 1);
        n_cy   = i_ext.min_row + (sh >> 1);
        n_span = (sw > sh) ? sw : sh;

        n_num  = sbbl_pkg::NUM_W'(r_span1) * sbbl_pkg::NUM_W'(sbbl_pkg::SCALE_MUL)
               + sbbl_pkg::NUM_W'(sbbl_pkg::SCALE_ADD);

        // Divide by 20 as a divide by 4 and a multiply by the reciprocal of 5.
        quart  = r_num2[sbbl_pkg::NUM_W-1:2];
        n_prod = sbbl_pkg::PROD_W'(quart) * sbbl_pkg::PROD_W'(sbbl_pkg::RECIP5);

        side   = sbbl_pkg::SIDE_W'(r_prod3 >> sbbl_pkg::RECIP5_SH);
        half   = sbbl_pkg::POS_W'(side >> 1);
        left   = (r_cx3 > half) ? (r_cx3 - half) : '0;
        top    = (r_cy3 > half) ? (r_cy3 - half) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1    <= i_ext_valid;
                r_e1    <= !i_ext.seen;
                r_span1 <= n_span;
                r_cx1   <= n_cx;
                r_cy1   <= n_cy;
            end
            if (rdy2) begin
                r_v2   <= r_v1;
                r_e2   <= r_e1;
                r_num2 <= n_num;
                r_cx2  <= r_cx1;
                r_cy2  <= r_cy1;
            end
            if (rdy3) begin
                r_v3    <= r_v2;
                r_e3    <= r_e2;
                r_prod3 <= n_prod;
                r_cx3   <= r_cx2;
                r_cy3   <= r_cy2;
            end
            if (rdy4) begin
                r_v4        <= r_v3;
                r_box.empty <= r_e3;
                r_box.left  <= r_e3 ? '0 : sbbl_pkg::OUT_POS_W'(left);
                r_box.top   <= r_e3 ? '0 : sbbl_pkg::OUT_POS_W'(top);
                r_box.side  <= r_e3 ? '0 : side;
            end
        end
    end

    assign o_ext_ready = rdy1;
    assign o_box       = r_box;
    assign o_valid     = r_v4;

endmodule

FILE: design/sbbl_checker.sv
// ----------------------------------------------------------------------------
// sbbl_checker
// Port-level checks on the box output, bound to the top level.
// ----------------------------------------------------------------------------
`include "square_bounding_box_of_lit_pixels_unit_defines.svh"

module sbbl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic [11:0] o_box_left,
    input logic [11:0] o_box_top,
    input logic [12:0] o_box_side,
    input logic        o_box_empty
);

    logic [37:0] box_word;
    logic        fields_zero;

    assign box_word    = {o_box_left, o_box_top, o_box_side, o_box_empty};
    assign fields_zero = (o_box_left == 12'd0) && (o_box_top == 12'd0)
                      && (o_box_side == 13'd0);

    // A stalled box stays on the port unchanged.
    `SBBL_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(box_word))

    // An empty frame reports all fields as zero.
    `SBBL_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && o_box_empty, fields_zero)

    // The side never exceeds the scaled largest span.
    `SBBL_ASSERT_IMP(a_side_max, i_clk, i_rst_n, o_valid, o_box_side <= 13'd4710)

    // Nothing is shown right after reset.
    `SBBL_ASSERT_NXT_ALL(a_rst_idle, i_clk, !i_rst_n, !o_valid)

endmodule

bind square_bounding_box_of_lit_pixels_unit sbbl_checker u_sbbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_stall     (i_stall),
    .o_valid     (o_valid),
    .o_box_left  (o_box_left),
    .o_box_top   (o_box_top),
    .o_box_side  (o_box_side),
    .o_box_empty (o_box_empty)
);

FILE: tb/sv/square_bounding_box_of_lit_pixels_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square bounding box unit test
// Streams raster frames of pixel words into the unit, tracks the lit extremes
// alongside it and checks every box word that comes out against the box worked
// out here. Frame sizes change between frames and in the middle of one, both
// handshakes idle at random and the output is held off long enough to fill
// the pipeline.
// ----------------------------------------------------------------------------
module square_bounding_box_of_lit_pixels_unit_test;

    // Cycles that pass after the last expected box before the unit counts as
    // quiet.
    localparam int SETTLE_CYCLES    = 8;
    // Cycles waited after the final box for anything left in flight.
    localparam int END_CYCLES       = 16;
    // Length of the long output hold-off.
    localparam int SINK_HOLD_CYCLES = 300;
    // Cycles with no word moving on any channel before the run is called hung.
    localparam int QUIET_LIMIT      = 4000;
    // Random pixels sent after the directed tests.
    localparam int RANDOM_PIXELS    = 160;

    // Register indexes that the unit does not decode.
    localparam logic [sbbl_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam logic [sbbl_pkg::CFG_IDX_W-1:0] REG_LAST  = 8'hFF;

    // A pixel with a fixed colour at a fixed position of the next frame.
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_lit_spot;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                           i_valid;
    logic                           o_stall;
    logic [7:0]                     i_blue;
    logic [7:0]                     i_green;
    logic [7:0]                     i_red;
    logic                           o_valid;
    logic                           i_stall;
    logic [11:0]                    o_box_left;
    logic [11:0]                    o_box_top;
    logic [12:0]                    o_box_side;
    logic                           o_box_empty;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [sbbl_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sbbl_pkg::CFG_W-1:0]     i_cfg_data;

    // Idling switches for the pixel sender and the box receiver, and the
    // request for one long hold-off on the box side.
    bit feed_idle     = 1'b0;
    bit sink_idle     = 1'b0;
    bit sink_hold_req = 1'b0;

    // Programmed frame size and the running state of the current frame.
    logic [sbbl_pkg::CFG_W-1:0] width_reg;
    logic [sbbl_pkg::CFG_W-1:0] height_reg;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      lo_col;
    int unsigned      hi_col;
    int unsigned      lo_row;
    int unsigned      hi_row;
    bit               lit_seen;

    sbbl_pkg::t_box pending_boxes[$];
    t_lit_spot      spots[$];
    int unsigned pixels_sent    = 0;
    int unsigned boxes_checked  = 0;
    int unsigned reg_writes     = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    square_bounding_box_of_lit_pixels_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_box_left  (o_box_left),
        .o_box_top   (o_box_top),
        .o_box_side  (o_box_side),
        .o_box_empty (o_box_empty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Frame tracking
    // ------------------------------------------------------------------------

    // A size register of zero counts as one; anything above MAX_DIM saturates.
    function automatic int unsigned dim_of(input logic [sbbl_pkg::CFG_W-1:0] size);
        int unsigned dim;
        dim = size;
        if (dim == 0) begin
            dim = 1;
        end else if (dim > sbbl_pkg::MAX_DIM) begin
            dim = sbbl_pkg::MAX_DIM;
        end
        return dim;
    endfunction

    function automatic void clear_frame();
        col_pos  = 0;
        row_pos  = 0;
        lo_col   = '1;
        hi_col   = 0;
        lo_row   = '1;
        hi_row   = 0;
        lit_seen = 1'b0;
    endfunction

    // Advances the frame by one accepted pixel and queues the box when that
    // pixel closes the frame.
    function automatic void track_pixel(input logic [7:0] blue, green, red);
        int unsigned    w;
        int unsigned    h;
        int unsigned    span_col;
        int unsigned    span_row;
        int unsigned    mid_col;
        int unsigned    mid_row;
        int unsigned    side;
        int unsigned    half;
        int unsigned    left;
        int unsigned    top;
        sbbl_pkg::t_box box;
        w = dim_of(width_reg);
        h = dim_of(height_reg);
        if ((blue | green | red) != 8'h00) begin
            if (col_pos < lo_col) lo_col = col_pos;
            if (col_pos > hi_col) hi_col = col_pos;
            if (row_pos < lo_row) lo_row = row_pos;
            if (row_pos > hi_row) hi_row = row_pos;
            lit_seen = 1'b1;
        end
        // A counter left past the last column or row by a size change simply
        // closes that row or the frame on this pixel.
        if (col_pos + 1 < w) begin
            col_pos++;
            return;
        end
        if (row_pos + 1 < h) begin
            col_pos = 0;
            row_pos++;
            return;
        end
        box = '0;
        if (!lit_seen) begin
            box.empty = 1'b1;
        end else begin
            span_col = hi_col - lo_col;
            span_row = hi_row - lo_row;
            mid_col  = lo_col + span_col / 2;
            mid_row  = lo_row + span_row / 2;
            side     = ((span_col > span_row ? span_col : span_row) * 23 + 19) / 20;
            half     = side / 2;
            left     = (mid_col > half) ? mid_col - half : 0;
            top      = (mid_row > half) ? mid_row - half : 0;
            box.left = left[sbbl_pkg::OUT_POS_W-1:0];
            box.top  = top[sbbl_pkg::OUT_POS_W-1:0];
            box.side = side[sbbl_pkg::SIDE_W-1:0];
        end
        pending_boxes = {pending_boxes, box};
        clear_frame();
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Offers one pixel word and returns at the edge that takes it. Valid stays
    // high into the next word when no gap is drawn.
    task automatic send_pixel(input logic [7:0] blue, green, red);
        int unsigned gap;
        gap = feed_idle ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_blue  <= blue;
        i_green <= green;
        i_red   <= red;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        track_pixel(blue, green, red);
        pixels_sent++;
    endtask

    // Sends the pixel at the current position: a planted spot if one sits
    // there, else lit with the given chance, else dark.
    task automatic send_next_pixel(input int unsigned lit_pct);
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        bit         planted;
        blue    = 8'h00;
        green   = 8'h00;
        red     = 8'h00;
        planted = 1'b0;
        foreach (spots[k]) begin
            if (spots[k].col == col_pos && spots[k].row == row_pos) begin
                blue    = spots[k].blue;
                green   = spots[k].green;
                red     = spots[k].red;
                planted = 1'b1;
            end
        end
        if (!planted && $urandom_range(0, 99) < lit_pct) begin
            // Each byte is dark a third of the time so single-channel pixels
            // turn up often.
            do begin
                blue  = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
                green = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
                red   = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
            end while ({blue, green, red} == 24'h0);
        end
        send_pixel(blue, green, red);
    endtask

    task automatic send_pixels(input int unsigned count, input int unsigned lit_pct);
        repeat (count) send_next_pixel(lit_pct);
    endtask

    // Runs the current frame to its end, then forgets the planted spots.
    task automatic send_frame(input int unsigned lit_pct);
        do begin
            send_next_pixel(lit_pct);
        end while (col_pos != 0 || row_pos != 0);
        spots.delete();
    endtask

    task automatic add_spot(input int unsigned col, row, input logic [7:0] blue, green, red);
        t_lit_spot spot;
        spot.col   = col[11:0];
        spot.row   = row[11:0];
        spot.blue  = blue;
        spot.green = green;
        spot.red   = red;
        spots      = {spots, spot};
    endtask

    // Stops offering pixels and waits until every box is out and the
    // pipeline has had time to go quiet.
    task automatic wait_for_boxes();
        i_valid <= 1'b0;
        while (pending_boxes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only go out while the unit is quiet.
    task automatic write_reg(input logic [sbbl_pkg::CFG_IDX_W-1:0] index,
                             input logic [sbbl_pkg::CFG_W-1:0] data);
        wait_for_boxes();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == sbbl_pkg::REG_FRAME_WIDTH) begin
            width_reg = data;
        end else if (index == sbbl_pkg::REG_FRAME_HEIGHT) begin
            height_reg = data;
        end
        reg_writes++;
    endtask

    task automatic set_frame_size(input logic [sbbl_pkg::CFG_W-1:0] width, height);
        write_reg(sbbl_pkg::REG_FRAME_WIDTH, width);
        write_reg(sbbl_pkg::REG_FRAME_HEIGHT, height);
    endtask

    // ------------------------------------------------------------------------
    // Box receiver: per box a random stall stretch, or one long hold-off when
    // asked for. Stall drops only after the stretch is over.
    // ------------------------------------------------------------------------
    initial begin : box_sink
        int unsigned hold;
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold = SINK_HOLD_CYCLES;
            end else begin
                hold = sink_idle ? $urandom_range(0, 11) : 0;
            end
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_valid && !sink_hold_req);
        end
    end

    // ------------------------------------------------------------------------
    // Box checker: every box word taken is matched with the oldest box
    // expected, field by field.
    // ------------------------------------------------------------------------
    function automatic void report_field(input string field, input logic [31:0] want, got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatch_count++;
    endfunction

    always @(posedge i_clk) begin
        sbbl_pkg::t_box want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t: box word (left %0d, top %0d, side %0d, empty %0b)",
                         $time, o_box_left, o_box_top, o_box_side, o_box_empty);
                $display("%0t: expected no box word", $time);
                mismatch_count++;
            end else begin
                want = pending_boxes.pop_front();
                if (o_box_left !== want.left)   report_field("box_left", want.left, o_box_left);
                if (o_box_top !== want.top)     report_field("box_top", want.top, o_box_top);
                if (o_box_side !== want.side)   report_field("box_side", want.side, o_box_side);
                if (o_box_empty !== want.empty) report_field("box_empty", want.empty, o_box_empty);
                boxes_checked++;
            end
        end
    end

    // Watchdog: a long run of cycles in which no word moves on any channel
    // means the unit has hung.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The reset width of 640: one row at full width marks column 639 and
    // leaves the frame open, so the reset height is above one. The frame is
    // then cut to two rows of one pixel, which closes it on the next pixel.
    task automatic test_reset_size();
        feed_idle = 1'b0;
        sink_idle = 1'b0;
        add_spot(639, 0, 8'h00, 8'h00, 8'h01);
        add_spot(0, 1, 8'h80, 8'h00, 8'h00);
        send_pixels(640, 0);
        set_frame_size(13'd1, 13'd2);
        send_frame(0);
    endtask

    // Small frames covering the empty frame, a single lit pixel, each colour
    // byte on its own, full-white pixels and the clamp at zero.
    task automatic test_directed_boxes();
        feed_idle = 1'b1;
        sink_idle = 1'b1;
        set_frame_size(13'd4, 13'd3);
        send_frame(0);
        add_spot(2, 1, 8'h01, 8'h00, 8'h00);
        send_frame(0);
        add_spot(0, 0, 8'h00, 8'h80, 8'h00);
        add_spot(3, 2, 8'h00, 8'h00, 8'h40);
        send_frame(0);
        add_spot(3, 0, 8'hFF, 8'hFF, 8'hFF);
        add_spot(3, 2, 8'hFF, 8'hFF, 8'hFF);
        send_frame(0);
        // Two frames back to back, every pixel lit.
        send_frame(100);
        send_frame(100);
    endtask

    // Saturating and degenerate sizes: register values above 4096 keep the
    // row open, a zero register counts as one. Each frame is cut short by a
    // later size write so it stays small.
    task automatic test_size_extremes();
        feed_idle = 1'b0;
        sink_idle = 1'b1;
        set_frame_size(13'h1FFF, 13'd0);
        add_spot(2, 0, 8'h01, 8'h00, 8'h00);
        add_spot(9, 0, 8'h00, 8'h00, 8'h01);
        send_pixels(10, 0);
        write_reg(sbbl_pkg::REG_FRAME_WIDTH, 13'd3);
        send_frame(0);
        // 4097 saturates as well and must not fold to a width of one.
        set_frame_size(13'd4097, 13'd1);
        add_spot(4, 0, 8'hFF, 8'hFF, 8'hFF);
        send_pixels(5, 0);
        write_reg(sbbl_pkg::REG_FRAME_WIDTH, 13'd0);
        send_frame(0);
        // A zero width gives one pixel per row under a 4096 row height.
        set_frame_size(13'd0, 13'd4096);
        add_spot(0, 0, 8'h00, 8'h7F, 8'h00);
        add_spot(0, 5, 8'hFE, 8'h00, 8'h00);
        send_pixels(6, 0);
        write_reg(sbbl_pkg::REG_FRAME_HEIGHT, 13'd1);
        send_frame(0);
        set_frame_size(13'd1, 13'h1FFF);
        add_spot(0, 2, 8'h55, 8'hAA, 8'h00);
        send_pixels(3, 30);
        write_reg(sbbl_pkg::REG_FRAME_HEIGHT, 13'd0);
        send_frame(30);
    endtask

    // Size changes in the middle of a frame: a narrower width wraps the row
    // at once, a lower height ends the frame with the current row, a wider
    // width just extends the row.
    task automatic test_mid_frame_resize();
        feed_idle = 1'b1;
        sink_idle = 1'b1;
        set_frame_size(13'd6, 13'd4);
        send_pixels(9, 50);
        write_reg(sbbl_pkg::REG_FRAME_WIDTH, 13'd3);
        send_pixels(1, 100);
        write_reg(sbbl_pkg::REG_FRAME_HEIGHT, 13'd2);
        send_frame(50);
        set_frame_size(13'd3, 13'd3);
        send_pixels(4, 50);
        write_reg(sbbl_pkg::REG_FRAME_WIDTH, 13'd7);
        send_frame(50);
    endtask

    // Writes to undecoded indexes must leave the frame size alone.
    task automatic test_unknown_register();
        feed_idle = 1'b1;
        sink_idle = 1'b0;
        set_frame_size(13'd2, 13'd2);
        write_reg(REG_SPARE, 13'd1);
        write_reg(REG_LAST, 13'h1FFF);
        send_frame(50);
        send_frame(50);
    endtask

    // One-pixel frames give a box per pixel. The receiver holds off long
    // enough for the pipeline to fill and stall the pixel side, then the
    // sender waits for the backlog to drain before carrying on.
    task automatic test_backpressure();
        set_frame_size(13'd1, 13'd1);
        feed_idle     = 1'b0;
        sink_idle     = 1'b0;
        sink_hold_req = 1'b1;
        send_pixels(48, 60);
        wait_for_boxes();
        sink_idle = 1'b1;
        send_pixels(24, 60);
        set_frame_size(13'd2, 13'd1);
        feed_idle = 1'b1;
        send_pixels(24, 60);
    endtask

    // Random frames, mostly small so boxes come often, with the size changed
    // every few frames and now and then in the middle of one.
    task automatic test_random_frames();
        int unsigned first;
        int unsigned lit_pct;
        logic [sbbl_pkg::CFG_W-1:0] width;
        logic [sbbl_pkg::CFG_W-1:0] height;
        first = pixels_sent;
        while (pixels_sent - first < RANDOM_PIXELS) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 7))
                    0:       width = 13'd0;
                    1:       width = 13'd1;
                    6:       width = 13'($urandom_range(9, 64));
                    default: width = 13'($urandom_range(2, 8));
                endcase
                height = 13'($urandom_range(0, 6));
                set_frame_size(width, height);
            end
            feed_idle = ($urandom_range(0, 2) != 0);
            sink_idle = ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 3))
                0:       lit_pct = 0;
                1:       lit_pct = 5;
                2:       lit_pct = 30;
                default: lit_pct = 90;
            endcase
            if ($urandom_range(0, 7) == 0) begin
                send_pixels($urandom_range(1, 6), lit_pct);
                set_frame_size(13'($urandom_range(0, 8)), 13'($urandom_range(0, 5)));
            end
            send_frame(lit_pct);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_blue      <= 8'h00;
        i_green     <= 8'h00;
        i_red       <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= sbbl_pkg::REG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        width_reg   = 13'(sbbl_pkg::FRAME_WIDTH_RST);
        height_reg  = 13'(sbbl_pkg::FRAME_HEIGHT_RST);
        clear_frame();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_directed_boxes();
        test_size_extremes();
        test_mid_frame_resize();
        test_unknown_register();
        test_backpressure();
        test_random_frames();

        wait_for_boxes();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Sent %0d pixels in frames from 1x1 up to 640 wide, checked %0d boxes,",
                 pixels_sent, boxes_checked);
        $display("issued %0d register writes; %0d field mismatches.", reg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/sbbl_pkg.sv
design/sbbl_frame_acc.sv
design/sbbl_box_calc.sv
design/square_bounding_box_of_lit_pixels_unit.sv
design/sbbl_checker.sv
tb/sv/square_bounding_box_of_lit_pixels_unit_test.sv
